### design/spa_pkg.sv
// Shared types and constants for the stepper angle positioner.
// No dependencies; every other design file imports this package.
package spa_pkg;

   // Angle units: 1/16 degree, one revolution is 360 * 16.
   localparam int unsigned ANGLE_FULL   = 5760;
   localparam int unsigned ANGLE_W      = 14;
   // Fraction bits of the fixed-point angle to step scale factor.
   localparam int unsigned SCALE_FRAC   = 26;

   localparam int unsigned PERIOD_W     = 16;
   localparam int unsigned COIL_W       = 5;
   localparam int unsigned POS_OUT_W    = 8;

   // CSR map: register index is paddr[2].
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        CSR_STEP_PERIOD = 1'b0;
   localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET = 16'd5;

   localparam logic MODE_TARGET = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   typedef struct packed {
      logic advance;
      logic mode;
   } ctl_type;

   typedef struct packed {
      logic [COIL_W-1:0]    coil_pattern;
      logic                 stepped;
      logic                 moving;
      logic [POS_OUT_W-1:0] position;
   } res_type;

   // Full-step coil drive sequence.
   function automatic logic [COIL_W-1:0] coil_lookup(input logic [1:0] phase);
      logic [COIL_W-1:0] pat;
      case (phase)
         2'd0:    pat = 5'h18;
         2'd1:    pat = 5'h0A;
         2'd2:    pat = 5'h06;
         2'd3:    pat = 5'h14;
         default: pat = 5'h18;
      endcase
      return pat;
   endfunction

endpackage

### design/spa_target.sv
// Angle to step-index conversion: reduce mod 360 degrees, scale, round.
// Depends on spa_pkg.
module spa_target
   import spa_pkg::*;
#(
   parameter int unsigned STEPS_PER_REVOLUTION = 200,
   localparam int unsigned PW = $clog2(STEPS_PER_REVOLUTION)
) (
   input  logic signed [ANGLE_W-1:0] angle,
   output logic [PW-1:0]             target
);

   localparam int unsigned R_W    = 13;
   localparam int unsigned PROD_W = R_W + SCALE_FRAC + 1;
   // ceil(S * 2^FRAC / 5760); the overshoot stays below one 1/5760 gap.
   localparam longint unsigned SCALE_L =
      ((longint'(STEPS_PER_REVOLUTION) << SCALE_FRAC) + longint'(ANGLE_FULL) - 1)
      / longint'(ANGLE_FULL);
   localparam logic [PROD_W-1:0] SCALE    = PROD_W'(SCALE_L);
   localparam logic [PROD_W-1:0] HALF_RND = PROD_W'(64'd1 << (SCALE_FRAC - 1));
   localparam logic signed [ANGLE_W:0] FULL_S  = (ANGLE_W+1)'(ANGLE_FULL);
   localparam logic signed [ANGLE_W:0] NFULL_S = -((ANGLE_W+1)'(ANGLE_FULL));
   localparam logic [PW:0] STEPS_W = (PW+1)'(STEPS_PER_REVOLUTION);

   logic signed [ANGLE_W:0] a_ext;
   logic signed [ANGLE_W:0] a_red;
   logic [R_W-1:0]          r;
   logic [PROD_W-1:0]       scaled;
   logic [PW:0]             idx;

   always_comb begin
      a_ext = {angle[ANGLE_W-1], angle};
      // 14-bit angles span less than three turns: at most two corrections.
      if (a_ext < NFULL_S) begin
         a_red = a_ext + FULL_S + FULL_S;
      end else if (a_ext < 0) begin
         a_red = a_ext + FULL_S;
      end else if (a_ext >= FULL_S) begin
         a_red = a_ext - FULL_S;
      end else begin
         a_red = a_ext;
      end
      r      = R_W'(a_red);
      scaled = PROD_W'(r) * SCALE + HALF_RND;
      idx    = (PW+1)'(scaled >> SCALE_FRAC);
      if (idx == STEPS_W) begin
         target = '0;
      end else begin
         target = PW'(idx);
      end
   end

endmodule

### design/spa_core.sv
// Motor state (position, remaining steps, phase, tick count) and result register.
// Depends on spa_pkg.
module spa_core
   import spa_pkg::*;
#(
   parameter int unsigned STEPS_PER_REVOLUTION = 200,
   localparam int unsigned PW = $clog2(STEPS_PER_REVOLUTION)
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  logic [PW-1:0]       target,
   input  logic [PERIOD_W-1:0] step_period,
   output res_type             res
);

   localparam int unsigned DW = PW + 2;
   localparam logic signed [DW-1:0] REV_S   = DW'(STEPS_PER_REVOLUTION);
   localparam logic signed [DW-1:0] HALF_S  = DW'(STEPS_PER_REVOLUTION / 2);
   localparam logic signed [DW-1:0] NHALF_S = -(DW'(STEPS_PER_REVOLUTION / 2));
   localparam logic                 REV_EVEN = (STEPS_PER_REVOLUTION % 2) == 0;
   localparam logic [PW-1:0]        LAST_POS = PW'(STEPS_PER_REVOLUTION - 1);

   logic [PW-1:0]        pos_ff, pos_in;
   logic signed [PW:0]   rem_ff, rem_in;
   logic [1:0]           phase_ff, phase_in;
   logic [PERIOD_W-1:0]  tick_ff, tick_in;
   res_type              res_ff, res_in;

   logic signed [DW-1:0] delta, delta_adj;
   logic [PERIOD_W-1:0]  tick_inc;
   logic                 stepped;

   always_comb begin
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      stepped  = 1'b0;
      tick_inc = tick_ff + 1'b1;

      // Shortest way round; an exact half turn goes clockwise.
      delta = signed'({2'b00, target}) - signed'({2'b00, pos_ff});
      if (delta > HALF_S) begin
         delta_adj = delta - REV_S;
      end else if (delta < NHALF_S || (REV_EVEN && delta == NHALF_S)) begin
         delta_adj = delta + REV_S;
      end else begin
         delta_adj = delta;
      end

      if (ctl.mode == MODE_TARGET) begin
         rem_in  = (PW+1)'(delta_adj);
         tick_in = '0;
      end else if (rem_ff == 0) begin
         tick_in = '0;
      end else if (tick_inc < step_period) begin
         tick_in = tick_inc;
      end else begin
         tick_in = '0;
         stepped = 1'b1;
         if (rem_ff > 0) begin
            phase_in = phase_ff + 2'd1;
            pos_in   = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
            rem_in   = rem_ff - 1'b1;
         end else begin
            phase_in = phase_ff - 2'd1;
            pos_in   = (pos_ff == '0) ? LAST_POS : pos_ff - 1'b1;
            rem_in   = rem_ff + 1'b1;
         end
      end

      res_in.coil_pattern = coil_lookup(phase_in);
      res_in.stepped      = stepped;
      res_in.moving       = (rem_in != 0);
      res_in.position     = POS_OUT_W'(pos_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rem_ff   <= '0;
         phase_ff <= '0;
         tick_ff  <= '0;
      end else if (ctl.advance) begin
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

   // A target item never steps.
   a_target_no_step: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && ctl.mode == MODE_TARGET |=> !res_ff.stepped)
      else $error("target item produced a step");

   // Idle tick: no step and the tick counter stays cleared.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && ctl.mode == MODE_TICK && rem_ff == 0
      |=> !res_ff.stepped && tick_ff == '0)
      else $error("idle tick changed state");

   // Every step moves the phase.
   a_step_phase: assert property (@(posedge clock) disable iff (reset)
      ctl.advance && stepped |=> phase_ff != $past(phase_ff))
      else $error("step without phase change");

   // The moving flag tracks the remaining step count.
   a_moving: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |=> res_ff.moving == (rem_ff != 0))
      else $error("moving flag out of step with remaining count");

endmodule

### design/stepper_angle_positioner.sv
// Stepper angle positioner: an item passes from req transfer to rsp_valid
// through the input register, then state update and result register.
// Throughput: one item per cycle unless stalled; state update is the loop.
// A stalled result holds; the input register still takes one more item.
// Synchronous active-high reset clears position, phase, remaining steps,
// tick count and both valids, and sets step_period to 5.
module stepper_angle_positioner
   import spa_pkg::*;
#(
   parameter int unsigned STEPS_PER_REVOLUTION = 200
) (
   input  logic                     clock,
   input  logic                     reset,
   // item input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic signed [ANGLE_W-1:0] req_target_angle,
   // result output
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COIL_W-1:0]        rsp_coil_pattern,
   output logic                     rsp_stepped,
   output logic                     rsp_moving,
   output logic [POS_OUT_W-1:0]     rsp_position,
   // APB-style register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int unsigned PW = $clog2(STEPS_PER_REVOLUTION);

   // input register
   logic                      in_valid_ff, in_valid_in;
   logic                      mode_ff;
   logic signed [ANGLE_W-1:0] angle_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0]       step_period_ff;

   ctl_type                   ctl;
   res_type                   res;
   logic [PW-1:0]             target;
   logic                      advance;
   logic                      csr_wr;

   // The held item moves into the result register whenever the result slot
   // is empty or is being taken this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the input register; no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= req_mode;
         angle_ff <= req_target_angle;
      end
   end

   // Register port: one register, step_period, at byte 0.
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff <= STEP_PERIOD_RESET;
      end else if (csr_wr && paddr[2] == CSR_STEP_PERIOD) begin
         step_period_ff <= pwdata[PERIOD_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_STEP_PERIOD) begin
         prdata = {16'd0, step_period_ff};
      end else begin
         prdata = '0;
      end
   end

   // angle to step index, straight from the input register
   spa_target #(
      .STEPS_PER_REVOLUTION(STEPS_PER_REVOLUTION)
   ) u_target (
      .angle  (angle_ff),
      .target (target)
   );

   assign ctl = '{advance: advance, mode: mode_ff};

   spa_core #(
      .STEPS_PER_REVOLUTION(STEPS_PER_REVOLUTION)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .target      (target),
      .step_period (step_period_ff),
      .res         (res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coil_pattern = res.coil_pattern;
   assign rsp_stepped      = res.stepped;
   assign rsp_moving       = res.moving;
   assign rsp_position     = res.position;

endmodule
